[src/sha_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, round constants and round functions for the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha_out_t;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] r;
        begin
            unique case (i)
                3'd0: r = 32'h6a09e667;
                3'd1: r = 32'hbb67ae85;
                3'd2: r = 32'h3c6ef372;
                3'd3: r = 32'ha54ff53a;
                3'd4: r = 32'h510e527f;
                3'd5: r = 32'h9b05688c;
                3'd6: r = 32'h1f83d9ab;
                default: r = 32'h5be0cd19;
            endcase
            return r;
        end
    endfunction

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

[src/sha_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 input queue
// Accept input beats, drop empty ones, and queue the rest for the core.
// ----------------------------------------------------------------------------
module sha_front
    import sha_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire sha_in_t in_beat,
    input  wire logic    in_valid,
    output logic         in_stall,
    output sha_in_t      q_beat,
    output logic         q_valid,
    input  wire logic    q_pop
);
    sha_in_t        mem [QDEPTH];
    logic [QAW:0]   cnt_reg, cnt_next;
    logic [QAW-1:0] wr_reg, rd_reg;
    logic           push, pop;

    assign in_stall = (cnt_reg == QDEPTH[QAW:0]);
    assign push     = in_valid && !in_stall && (in_beat.has_byte || in_beat.end_of_message);
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_beat   = mem[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= in_beat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wr_reg  <= '0;
            rd_reg  <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
        end
    end
endmodule
`default_nettype wire

[src/sha_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 core
// Absorb bytes, pad, run one compression round per cycle, emit the digest.
// ----------------------------------------------------------------------------
module sha_core
    import sha_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire sha_in_t q_beat,
    input  wire logic    q_valid,
    output logic         q_pop,
    output sha_out_t     out_beat,
    output logic         out_valid,
    input  wire logic    out_stall
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_RND  = 3'd3;
    localparam logic [2:0] S_ADD  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]  st_reg;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic [5:0]  rnd_reg;
    logic [2:0]  oi_reg;
    logic        fin_reg;
    logic        lenblk_reg;
    logic        pad_reg;

    logic [31:0] t1, t2, wn, s0, s1, wcur;
    logic [4:0]  lane_lsb;

    assign q_pop     = (st_reg == S_IDLE) && q_valid;
    assign out_valid = (st_reg == S_OUT);
    assign out_beat.digest_word = h_reg[oi_reg];
    assign out_beat.word_index  = oi_reg;
    assign out_beat.last_word   = (oi_reg == 3'd7);
    assign lane_lsb  = {~fill_reg[1:0], 3'b000};

    always_comb
    begin
        wcur = w_reg[0];
        s0 = ror(w_reg[1], 7) ^ ror(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = ror(w_reg[14], 17) ^ ror(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wn = s1 + w_reg[9] + s0 + w_reg[0];
        t1 = v_reg[7] + (ror(v_reg[4], 6) ^ ror(v_reg[4], 11) ^ ror(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + ROUND_K[rnd_reg] + wcur;
        t2 = (ror(v_reg[0], 2) ^ ror(v_reg[0], 13) ^ ror(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            S_IDLE:
            begin
                if (q_pop && q_beat.has_byte)
                    w_reg[fill_reg[5:2]][lane_lsb +: 8] <= q_beat.data_byte;
            end
            S_PAD:
            begin
                if (lenblk_reg)
                begin
                    for (int i = 0; i < 64; i++)
                    begin
                        if (i >= 56)
                            w_reg[i/4][8*(3-i%4) +: 8] <= len_reg[8*(63-i) +: 8];
                        else if (6'(i) >= fill_reg)
                            w_reg[i/4][8*(3-i%4) +: 8] <= 8'h00;
                    end
                end
                else
                begin
                    for (int i = 0; i < 64; i++)
                    begin
                        if (6'(i) == fill_reg)
                            w_reg[i/4][8*(3-i%4) +: 8] <= PAD_BYTE;
                        else if (6'(i) > fill_reg)
                            w_reg[i/4][8*(3-i%4) +: 8] <= 8'h00;
                    end
                end
            end
            S_LOAD:
            begin
                for (int i = 0; i < 8; i++)
                    v_reg[i] <= h_reg[i];
            end
            S_RND:
            begin
                for (int i = 0; i < 15; i++)
                    w_reg[i] <= w_reg[i+1];
                w_reg[15] <= wn;
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_IDLE;
            fill_reg   <= '0;
            len_reg    <= '0;
            rnd_reg    <= '0;
            oi_reg     <= '0;
            fin_reg    <= 1'b0;
            lenblk_reg <= 1'b0;
            pad_reg    <= 1'b0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= init_h(3'(i));
        end
        else
        begin
            unique case (st_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        fin_reg    <= q_beat.end_of_message;
                        lenblk_reg <= 1'b0;
                        pad_reg    <= 1'b0;
                        if (q_beat.has_byte)
                        begin
                            fill_reg <= fill_reg + 1'b1;
                            len_reg  <= len_reg + 64'd8;
                            if (fill_reg == 6'd63)
                                st_reg <= S_LOAD;
                            else if (q_beat.end_of_message)
                                st_reg <= S_PAD;
                        end
                        else if (q_beat.end_of_message)
                            st_reg <= S_PAD;
                    end
                end
                S_PAD:
                begin
                    st_reg <= S_LOAD;
                    if (!lenblk_reg)
                    begin
                        pad_reg <= 1'b1;
                        if (fill_reg < LEN_POS)
                        begin
                            lenblk_reg <= 1'b1;
                            fill_reg   <= fill_reg + 1'b1;
                            st_reg     <= S_PAD;
                        end
                        else
                            fill_reg <= '0;
                    end
                end
                S_LOAD:
                begin
                    rnd_reg <= '0;
                    st_reg  <= S_RND;
                end
                S_RND:
                begin
                    rnd_reg <= rnd_reg + 1'b1;
                    if (rnd_reg == 6'd63)
                        st_reg <= S_ADD;
                end
                S_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    fill_reg <= '0;
                    if (!fin_reg)
                        st_reg <= S_IDLE;
                    else if (lenblk_reg)
                    begin
                        oi_reg <= '0;
                        st_reg <= S_OUT;
                    end
                    else
                    begin
                        lenblk_reg <= pad_reg;
                        st_reg     <= S_PAD;
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        oi_reg <= oi_reg + 1'b1;
                        if (oi_reg == 3'd7)
                        begin
                            st_reg  <= S_IDLE;
                            fin_reg <= 1'b0;
                            len_reg <= '0;
                            for (int i = 0; i < 8; i++)
                                h_reg[i] <= init_h(3'(i));
                        end
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[src/sha256_hash_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 hasher top level
// Byte-wide SHA-256: a four-beat input queue feeds a core that runs one
// round per cycle. A byte beat that does not complete a 64-byte block is
// absorbed in the idle state; a block-completing byte adds a compression
// (load, 64 rounds, chain add). End of message adds one or two padded
// compressions, then eight digest beats, word 0 first. The single shared
// round unit sets the rate.
// ----------------------------------------------------------------------------
module sha256_hash_top
    import sha_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire sha_in_t in_data,
    input  wire logic    in_valid,
    output logic         in_stall,
    output sha_out_t     out_data,
    output logic         out_valid,
    input  wire logic    out_stall
);
    sha_in_t q_beat;
    logic    q_valid, q_pop;

    sha_front u_front (
        .clk(clk), .rst_n(rst_n), .in_beat(in_data), .in_valid(in_valid),
        .in_stall(in_stall), .q_beat(q_beat), .q_valid(q_valid), .q_pop(q_pop)
    );

    sha_core u_core (
        .clk(clk), .rst_n(rst_n), .q_beat(q_beat), .q_valid(q_valid), .q_pop(q_pop),
        .out_beat(out_data), .out_valid(out_valid), .out_stall(out_stall)
    );

    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.last_word == (out_data.word_index == 3'd7)))
        else $error("last_word mismatch");
    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.last_word |=>
            out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
        else $error("digest index skipped");
    a_no_pop_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !q_pop)
        else $error("queue popped during digest");
endmodule
`default_nettype wire
